/* src/ring_sample_word_packer_core_macros.svh */
// Assertion macros shared by the packer's checker file.
`ifndef RING_SAMPLE_WORD_PACKER_CORE_MACROS_SVH
`define RING_SAMPLE_WORD_PACKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RSWP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RSWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rswp_pkg.sv */
// Types, codes and constants shared by the ring sample word packer.
`timescale 1ns / 1ps
`default_nettype none

package rswp_pkg;

  localparam int unsigned POS_BITS       = 16;
  localparam int unsigned LEN_BITS       = POS_BITS + 1;
  localparam int unsigned CNT_BITS       = $clog2(POS_BITS);
  localparam int unsigned SAFETY_SAMPLES = 512;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 17;

  // Action codes
  localparam logic [1:0] ACT_BEGIN   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RING_SAMPLES    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_IS_16BIT = 2'd1;

  localparam logic [LEN_BITS-1:0] RING_RESET    = 17'd4096;
  localparam logic [POS_BITS-1:0] POS_RESET     = POS_BITS'(SAFETY_SAMPLES);
  // Residue of the start position in the reset ring length
  localparam logic [POS_BITS-1:0] RES_RESET     = POS_BITS'(SAFETY_SAMPLES % 4096);
  localparam logic [17:0]         SAFETY_WIDE   = 18'(SAFETY_SAMPLES);

  typedef struct packed {
    logic [1:0]          action;
    logic                channel;
    logic [15:0]         read_position;
    logic [15:0]         request_count;
    logic [15:0]         sample;
  } item_t;

  typedef struct packed {
    logic [15:0]         granted_count;
    logic                word_valid;
    logic                word_channel;
    logic [15:0]         word_position;
    logic [31:0]         word_data;
    logic                dropped;
  } result_t;

  // Per-channel state: raw write position and its residue modulo the ring length
  typedef struct packed {
    logic [POS_BITS-1:0] wp;
    logic [POS_BITS-1:0] res;
    logic [31:0]         pword;
    logic [1:0]          pcount;
    logic [15:0]         grant;
  } chan_t;

  // Status of the position reduction unit
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [POS_BITS-1:0] rem0;
    logic [POS_BITS-1:0] rem1;
  } wrap_t;

  // Ring length: zero or anything above the position span means the full span
  function automatic logic [LEN_BITS-1:0] ring_len(input logic [CFG_DATA_BITS-1:0] rs);
    logic [LEN_BITS-1:0] full;
    full = {1'b1, {POS_BITS{1'b0}}};
    if ((rs == '0) || (rs > CFG_DATA_BITS'(full))) begin
      return full;
    end
    return LEN_BITS'(rs);
  endfunction

endpackage

`default_nettype wire

/* src/ring_sample_word_packer_core.sv */
// Top level of the two-channel ring sample word packer.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid_i/in_ready_o | action, channel, read_position,
//           |                      | request_count, sample
//   output  | out_valid_o/out_ready_i | granted_count, word_valid, word_channel,
//           |                      | word_position, word_data, dropped
//   config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle while no reduction pass runs and the output is not stalled: a beat
// is held in the input register and then leaves its result in the output register.
// Reset gives a ring of 4096 samples, 16-bit packing and positions at the gap.
// A write to ring_samples or a restart beat starts a pass of the serial
// reduction unit that brings both positions modulo the ring length; input
// beats wait for the start register and the pass. Config writes are always taken.
// A stalled output holds its result; the input register still takes one beat if empty.
`timescale 1ns / 1ps
`default_nettype none

module ring_sample_word_packer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic        channel_i,
  input  wire logic [15:0] read_position_i,
  input  wire logic [15:0] request_count_i,
  input  wire logic [15:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      granted_count_o,
  output logic             word_valid_o,
  output logic             word_channel_o,
  output logic [15:0]      word_position_o,
  output logic [31:0]      word_data_o,
  output logic             dropped_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [rswp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [rswp_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import rswp_pkg::*;

  logic                     s1_valid_q;
  item_t                    s1_item_q;
  logic                     out_valid_q;
  result_t                  out_res_q;
  logic [CFG_DATA_BITS-1:0] ring_q;
  logic                     is16_q;
  chan_t                    chan_q [2];
  logic                     wrap_start_q, wrap_start_d;
  logic                     cfg_wr;
  logic                     busy;
  logic                     advance;
  logic [LEN_BITS-1:0]      len;
  chan_t                    chan_next;
  result_t                  res_next;
  wrap_t                    wrap_stat;
  item_t                    in_item;

  assign in_item = '{action: action_i, channel: channel_i,
                     read_position: read_position_i,
                     request_count: request_count_i, sample: sample_i};

  assign len         = ring_len(ring_q);
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy        = wrap_start_q || wrap_stat.busy;
  assign advance     = s1_valid_q && !busy && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;

  // Start a reduction pass after a new ring length or a restart
  assign wrap_start_d = (cfg_wr && (cfg_index_i == REG_RING_SAMPLES)) ||
                        (advance && (s1_item_q.action == ACT_RESTART));

  rswp_step u_step (
    .item_i (s1_item_q),
    .chan_i (chan_q[s1_item_q.channel]),
    .len_i  (len),
    .is16_i (is16_q),
    .chan_o (chan_next),
    .res_o  (res_next)
  );

  rswp_wrap u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start_q),
    .len_i   (len),
    .wp0_i   (chan_q[0].wp),
    .wp1_i   (chan_q[1].wp),
    .stat_o  (wrap_stat)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q       <= RING_RESET;
      is16_q       <= 1'b1;
      wrap_start_q <= 1'b0;
    end else begin
      wrap_start_q <= wrap_start_d;
      if (cfg_wr) begin
        case (cfg_index_i)
          REG_RING_SAMPLES:    ring_q <= cfg_data_i;
          REG_SAMPLE_IS_16BIT: is16_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item;
    end
  end

  // Channel state: updated as a beat moves to the output, residues after a pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        chan_q[c] <= '{wp: POS_RESET, res: RES_RESET, pword: '0, pcount: '0, grant: '0};
      end
    end else if (advance) begin
      if (s1_item_q.action == ACT_RESTART) begin
        for (int c = 0; c < 2; c++) begin
          chan_q[c].wp     <= POS_RESET;
          chan_q[c].pword  <= '0;
          chan_q[c].pcount <= '0;
          chan_q[c].grant  <= '0;
        end
      end else begin
        chan_q[s1_item_q.channel] <= chan_next;
      end
    end else if (wrap_stat.done) begin
      chan_q[0].res <= wrap_stat.rem0;
      chan_q[1].res <= wrap_stat.rem1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_count_o = out_res_q.granted_count;
  assign word_valid_o    = out_res_q.word_valid;
  assign word_channel_o  = out_res_q.word_channel;
  assign word_position_o = out_res_q.word_position;
  assign word_data_o     = out_res_q.word_data;
  assign dropped_o       = out_res_q.dropped;

endmodule

`default_nettype wire

/* src/rswp_wrap.sv */
// Bit-serial reduction of both write positions modulo the ring length.
`timescale 1ns / 1ps
`default_nettype none

module rswp_wrap (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rswp_pkg::LEN_BITS-1:0] len_i,
  input  wire logic [rswp_pkg::POS_BITS-1:0] wp0_i,
  input  wire logic [rswp_pkg::POS_BITS-1:0] wp1_i,
  output rswp_pkg::wrap_t                   stat_o
);
  import rswp_pkg::*;

  logic                busy_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [LEN_BITS-1:0] rem0_q, rem1_q;
  logic [LEN_BITS-1:0] rem0_d, rem1_d;

  // One restoring step: bring in the next bit, subtract the length if it fits
  function automatic logic [LEN_BITS-1:0] rem_step(input logic [LEN_BITS-1:0] rem,
                                                   input logic nb,
                                                   input logic [LEN_BITS-1:0] len);
    logic [LEN_BITS:0] t;
    t = {rem, nb};
    if (t >= {1'b0, len}) begin
      t = t - {1'b0, len};
    end
    return t[LEN_BITS-1:0];
  endfunction

  assign rem0_d = rem_step(rem0_q, wp0_i[cnt_q], len_i);
  assign rem1_d = rem_step(rem1_q, wp1_i[cnt_q], len_i);

  // Sequencer: MSB first, one bit of each position per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem0_q <= '0;
      rem1_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_BITS'(POS_BITS - 1);
      rem0_q <= '0;
      rem1_q <= '0;
    end else if (busy_q) begin
      rem0_q <= rem0_d;
      rem1_q <= rem1_d;
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainders are below the length, so they fit the position width
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0) && !start_i;
  assign stat_o.rem0 = rem0_d[POS_BITS-1:0];
  assign stat_o.rem1 = rem1_d[POS_BITS-1:0];

endmodule

`default_nettype wire

/* src/rswp_step.sv */
// Per-beat logic: grant sums, lane packing and write position advance.
`timescale 1ns / 1ps
`default_nettype none

module rswp_step (
  input  wire rswp_pkg::item_t              item_i,
  input  wire rswp_pkg::chan_t              chan_i,
  input  wire logic [rswp_pkg::LEN_BITS-1:0] len_i,
  input  wire logic                         is16_i,
  output rswp_pkg::chan_t                   chan_o,
  output rswp_pkg::result_t                 res_o
);
  import rswp_pkg::*;

  logic [17:0]         span_fwd;
  logic [17:0]         room;
  logic [15:0]         grant;
  logic [1:0]          lane;
  logic                last;
  logic [2:0]          step;
  logic [31:0]         word;
  logic [LEN_BITS-1:0] t;
  logic [LEN_BITS-1:0] wrapped;

  // Modulo for ring lengths of one to three samples, where one subtract is not enough
  function automatic logic [2:0] small_mod(input logic [2:0] v, input logic [1:0] l);
    logic [2:0] r;
    r = v;
    for (int k = 0; k < 6; k++) begin
      if (r >= {1'b0, l}) begin
        r = r - {1'b0, l};
      end
    end
    return r;
  endfunction

  // Free space ahead of the write position, less the safety gap
  always_comb begin
    if (item_i.read_position < chan_i.wp) begin
      span_fwd = {2'b00, item_i.read_position} + {1'b0, len_i} - {2'b00, chan_i.wp};
    end else begin
      span_fwd = {2'b00, item_i.read_position} - {2'b00, chan_i.wp};
    end
    room  = (span_fwd > SAFETY_WIDE) ? span_fwd - SAFETY_WIDE : 18'd0;
    grant = ({2'b00, item_i.request_count} < room) ? item_i.request_count : room[15:0];
  end

  // Lane selection and insertion into the partial word
  always_comb begin
    word = chan_i.pword;
    if (is16_i) begin
      lane = {1'b0, chan_i.pcount[0]};
      last = lane[0];
      step = 3'd2;
      if (lane[0]) begin
        word[31:16] = item_i.sample;
      end else begin
        word[15:0] = item_i.sample;
      end
    end else begin
      lane = chan_i.pcount;
      last = (lane == 2'd3);
      step = 3'd4;
      for (int b = 0; b < 4; b++) begin
        if (lane == 2'(b)) begin
          word[b*8 +: 8] = item_i.sample[7:0];
        end
      end
    end
  end

  // Next write position from the residue, which is already below the length
  always_comb begin
    t = {1'b0, chan_i.res} + LEN_BITS'(step);
    if (len_i >= LEN_BITS'(4)) begin
      wrapped = (t >= len_i) ? t - len_i : t;
    end else begin
      wrapped = LEN_BITS'(small_mod(t[2:0], len_i[1:0]));
    end
  end

  // Next state and result
  always_comb begin
    chan_o = chan_i;
    res_o  = '0;
    case (item_i.action)
      ACT_BEGIN: begin
        chan_o.grant      = grant;
        res_o.granted_count = grant;
      end
      ACT_SAMPLE: begin
        res_o.word_channel = item_i.channel;
        if (chan_i.grant == '0) begin
          res_o.dropped = 1'b1;
        end else begin
          chan_o.grant = chan_i.grant - 1'b1;
          chan_o.pword = word;
          if (last) begin
            res_o.word_valid    = 1'b1;
            res_o.word_position = chan_i.wp;
            res_o.word_data     = word;
            chan_o.pcount       = 2'd0;
            chan_o.wp           = wrapped[POS_BITS-1:0];
            chan_o.res          = wrapped[POS_BITS-1:0];
          end else begin
            chan_o.pcount = lane + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rswp_checker.sv */
// Port-level checks on the packer's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "ring_sample_word_packer_core_macros.svh"

module rswp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] granted_count_o,
  input wire logic        word_valid_o,
  input wire logic [31:0] word_data_o,
  input wire logic        dropped_o
);

  // A dropped sample never also emits a word
  `RSWP_ASSERT_IMP(a_drop_no_word, out_valid_o && dropped_o, !word_valid_o, "word on dropped beat")

  // Only begin beats carry a grant, so a word beat shows none
  `RSWP_ASSERT_IMP(a_word_no_grant, out_valid_o && word_valid_o, granted_count_o == 16'd0,
                   "grant on word beat")

  // A dropped beat carries no grant either
  `RSWP_ASSERT_IMP(a_drop_no_grant, out_valid_o && dropped_o, granted_count_o == 16'd0,
                   "grant on dropped beat")

  // A stalled result holds
  `RSWP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(word_data_o) && $stable(granted_count_o),
                   "stalled result changed")

endmodule

bind ring_sample_word_packer_core rswp_checker u_rswp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .granted_count_o (granted_count_o),
  .word_valid_o    (word_valid_o),
  .word_data_o     (word_data_o),
  .dropped_o       (dropped_o)
);

`default_nettype wire
